### rtl/core/mmf3_pkg.sv
// ----------------------------------------------------------------------------
// mmf3_pkg
// Shared constants, codes and types of the 3x3 max / min / midpoint filter.
// ----------------------------------------------------------------------------
package mmf3_pkg;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned LINE_MAX_DEF = 2048;

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned WIDTH_W    = 12;
  localparam int unsigned HEIGHT_W   = 13;
  localparam int unsigned ROW_W      = HEIGHT_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [MODE_W-1:0] MODE_MAX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MID = 2'd2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_MODE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_e;

  // row_ok[0] / col_ok[0] refer to the upper row / left column
  typedef struct packed {
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic       emit;
    logic       last;
  } win_ctl_t;

  // col[0] upper line, col[1] middle line, col[2] incoming pixel
  typedef struct packed {
    logic [2:0][PIX_W-1:0] col;
    win_ctl_t              ctl;
  } col_entry_t;

endpackage

### rtl/core/mmf3_stream_if.sv
// ----------------------------------------------------------------------------
// mmf3 stream interfaces
// Valid / ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mmf3_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [mmf3_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output op, output pixel_in, input ready);
  modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface mmf3_out_if;
  logic                        valid;
  logic                        ready;
  logic [mmf3_pkg::PIX_W-1:0]  pixel_out;
  logic                        frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

### rtl/core/mmf3_front.sv
// ----------------------------------------------------------------------------
// mmf3_front
// Accepts items, tracks image position, classifies each window and reads and
// updates the line buffer memory; pushes one column entry per advance.
// ----------------------------------------------------------------------------
module mmf3_front #(
  parameter int unsigned LINE_MAX = mmf3_pkg::LINE_MAX_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  mmf3_in_if.sink                                in_i,
  input  logic [$clog2(LINE_MAX):0]              eff_w_i,
  input  logic [mmf3_pkg::HEIGHT_W-1:0]          eff_h_i,
  input  logic                                   restart_i,
  input  logic                                   room_i,
  output logic                                   push_o,
  output mmf3_pkg::col_entry_t                   entry_o
);

  localparam int unsigned CB  = $clog2(LINE_MAX);
  localparam int unsigned PNB = $clog2(LINE_MAX + 2);
  localparam int unsigned RW  = mmf3_pkg::ROW_W;
  localparam int unsigned PW  = mmf3_pkg::PIX_W;

  logic [CB-1:0]  c_q, c_d;
  logic [RW-1:0]  r_q, r_d;
  logic [PNB-1:0] pend_q, pend_d, pend_dec;

  logic              acc, adv, wrap, norm;
  logic [CB-1:0]     c_base, c_adv;
  logic [RW-1:0]     r_base, r_adv, h_ext;
  logic [CB:0]       c_inc;
  mmf3_pkg::win_ctl_t ctl;

  logic                b_valid_q;
  logic [CB-1:0]       b_ci_q;
  logic [PW-1:0]       b_pix_q;
  mmf3_pkg::win_ctl_t  b_ctl_q;
  logic                b_fwd_q;
  logic [2*PW-1:0]     b_fwd_data_q, rd_q, b_word, b_wdata;

  logic [2*PW-1:0] line_mem [LINE_MAX];

  assign in_i.ready = room_i;
  assign acc        = in_i.valid & in_i.ready;
  assign h_ext      = RW'(eff_h_i);

  always_comb begin
    adv = !in_i.op || (pend_q != '0);
    if (!in_i.op && (pend_q != '0)) begin
      c_base = '0;
      r_base = '0;
    end else begin
      c_base = c_q;
      r_base = r_q;
    end

    wrap = (c_base == '0) && (r_base >= RW'(2));
    norm = (c_base != '0) && (r_base != '0);

    ctl.emit = wrap | norm;
    ctl.last = wrap && (r_base == h_ext + RW'(1));
    if (wrap) begin
      ctl.row_ok = {r_base <= h_ext, 1'b1, r_base >= RW'(3)};
      ctl.col_ok = {1'b0, 1'b1, eff_w_i >= (CB+1)'(2)};
    end else begin
      ctl.row_ok = {r_base < h_ext, 1'b1, r_base >= RW'(2)};
      ctl.col_ok = {1'b1, 1'b1, c_base >= CB'(2)};
    end

    c_inc = {1'b0, c_base} + (CB+1)'(1);
    if (c_inc >= eff_w_i) begin
      c_adv = '0;
      r_adv = r_base + RW'(1);
    end else begin
      c_adv = c_inc[CB-1:0];
      r_adv = r_base;
    end
  end

  always_comb begin
    c_d      = c_q;
    r_d      = r_q;
    pend_d   = pend_q;
    pend_dec = pend_q - PNB'(1);
    if (restart_i) begin
      c_d    = '0;
      r_d    = '0;
      pend_d = '0;
    end else if (acc && adv) begin
      if (in_i.op) begin
        pend_d = pend_dec;
        if (pend_dec == '0) begin
          c_d = '0;
          r_d = '0;
        end else begin
          c_d = c_adv;
          r_d = r_adv;
        end
      end else begin
        c_d = c_adv;
        r_d = r_adv;
        if ((c_adv == '0) && (r_adv >= h_ext)) begin
          pend_d = PNB'(eff_w_i) + PNB'(1);
        end else begin
          pend_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q       <= '0;
      r_q       <= '0;
      pend_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      c_q       <= c_d;
      r_q       <= r_d;
      pend_q    <= pend_d;
      b_valid_q <= acc && adv;
    end
  end

  // stage b: merge forwarded word, write back shifted lines
  assign b_word  = b_fwd_q ? b_fwd_data_q : rd_q;
  assign b_wdata = {b_word[PW-1:0], b_pix_q};

  always_ff @(posedge clk_i) begin
    if (acc && adv) begin
      b_ci_q       <= c_base;
      b_pix_q      <= in_i.op ? '0 : in_i.pixel_in;
      b_ctl_q      <= ctl;
      b_fwd_q      <= b_valid_q && (b_ci_q == c_base);
      b_fwd_data_q <= b_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      line_mem[b_ci_q] <= b_wdata;
    end
    if (acc && adv) begin
      rd_q <= line_mem[c_base];
    end
  end

  assign push_o         = b_valid_q;
  assign entry_o.col[0] = b_word[2*PW-1:PW];
  assign entry_o.col[1] = b_word[PW-1:0];
  assign entry_o.col[2] = b_pix_q;
  assign entry_o.ctl    = b_ctl_q;

`ifndef ASSERT_OFF
  a_col_in_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, c_q} < eff_w_i)
    else $error("column count beyond row width");

  a_drain_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != '0) |-> (r_q >= h_ext))
    else $error("drain pending before last row finished");
`endif

endmodule

### rtl/core/mmf3_fifo.sv
// ----------------------------------------------------------------------------
// mmf3_fifo
// Short queue of column entries between front and back.
// ----------------------------------------------------------------------------
module mmf3_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mmf3_pkg::col_entry_t  entry_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output mmf3_pkg::col_entry_t  entry_o,
  output logic                  room_o
);

  localparam int unsigned DEPTH = mmf3_pkg::QUEUE_DEPTH;
  localparam int unsigned PTRW  = $clog2(DEPTH);
  localparam int unsigned CNTW  = $clog2(DEPTH + 1);

  mmf3_pkg::col_entry_t slot_q [DEPTH];
  logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q;

  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  // two free slots: one for the entry in flight, one for a new accept
  assign room_o  = (cnt_q <= CNTW'(DEPTH - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTRW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTRW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < CNTW'(DEPTH)))
    else $error("push into full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("pop from empty queue");
`endif

endmodule

### rtl/core/mmf3_back.sv
// ----------------------------------------------------------------------------
// mmf3_back
// Holds the window, reduces nine masked pixels to max / min / midpoint and
// drives the output register.
// ----------------------------------------------------------------------------
module mmf3_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mmf3_pkg::MODE_W-1:0]   mode_i,
  input  logic                          q_valid_i,
  input  mmf3_pkg::col_entry_t          entry_i,
  output logic                          pop_o,
  mmf3_out_if.source                    out_o
);

  localparam int unsigned PW = mmf3_pkg::PIX_W;

  // win_q[row][0] older column, win_q[row][1] newer column
  logic [2:0][1:0][PW-1:0] win_q;
  logic                    out_valid_q;
  logic [PW-1:0]           out_pix_q;
  logic                    out_last_q;

  logic [PW-1:0] cand [3][3];
  logic [PW-1:0] mx, mn, res;
  logic [PW:0]   sum;

  assign pop_o = q_valid_i && (!entry_i.ctl.emit || !out_valid_q || out_o.ready);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cand[i][0] = (entry_i.ctl.row_ok[i] && entry_i.ctl.col_ok[0]) ? win_q[i][0] : '0;
      cand[i][1] = (entry_i.ctl.row_ok[i] && entry_i.ctl.col_ok[1]) ? win_q[i][1] : '0;
      cand[i][2] = (entry_i.ctl.row_ok[i] && entry_i.ctl.col_ok[2]) ? entry_i.col[i] : '0;
    end
    mx = '0;
    mn = '1;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (cand[i][j] > mx) mx = cand[i][j];
        if (cand[i][j] < mn) mn = cand[i][j];
      end
    end
    sum = {1'b0, mx} + {1'b0, mn};
    case (mode_i)
      mmf3_pkg::MODE_MAX: res = mx;
      mmf3_pkg::MODE_MIN: res = mn;
      default:            res = sum[PW:1];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= entry_i.col[i];
        end
      end
      if (pop_o && entry_i.ctl.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.ctl.emit) begin
      out_pix_q  <= res;
      out_last_q <= entry_i.ctl.last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pixel_out  = out_pix_q;
  assign out_o.frame_last = out_last_q;

endmodule

### rtl/core/max_min_midpoint_filter_3x3_core.sv
// ----------------------------------------------------------------------------
// max_min_midpoint_filter_3x3_core
// Streaming 3x3 max / min / midpoint filter with zero border over a raster
// image, two line buffers in one memory and a 3x3 window.
// ----------------------------------------------------------------------------
//   channel   dir   handshake      payload
//   in_i      in    valid/ready    op, pixel_in
//   out_o     out   valid/ready    pixel_out, frame_last
//   cfg       in    cfg_we_i       cfg_index_i, cfg_wdata_i
//
// one item per cycle while in_i.ready is high; a result reaches out_o through the
// stage b registers and line memory read, the queue slot and the output register.
// in_i.ready drops when the four-entry queue holds more than two entries,
// which happens only while out_o stalls.
// reset clears counters, window and queue; the line memory is not cleared,
// entries never written are masked out by the border logic.
// ----------------------------------------------------------------------------
module max_min_midpoint_filter_3x3_core #(
  parameter int unsigned LINE_MAX = mmf3_pkg::LINE_MAX_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  mmf3_in_if.sink                            in_i,
  mmf3_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [mmf3_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mmf3_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned CB = $clog2(LINE_MAX);

  logic [mmf3_pkg::MODE_W-1:0]   mode_q;
  logic [mmf3_pkg::WIDTH_W-1:0]  width_q;
  logic [mmf3_pkg::HEIGHT_W-1:0] height_q;

  logic [CB:0]                   eff_w;
  logic [mmf3_pkg::HEIGHT_W-1:0] eff_h;
  logic                          restart;

  logic                  push, pop, q_valid, room;
  mmf3_pkg::col_entry_t  push_entry, pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mmf3_pkg::MODE_MAX;
      width_q  <= mmf3_pkg::WIDTH_RST;
      height_q <= mmf3_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (mmf3_pkg::cfg_idx_e'(cfg_index_i))
        mmf3_pkg::CFG_FILTER_MODE:  mode_q   <= cfg_wdata_i[mmf3_pkg::MODE_W-1:0];
        mmf3_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[mmf3_pkg::WIDTH_W-1:0];
        mmf3_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[mmf3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // a size write starts a new image
  assign restart = cfg_we_i &&
                   ((cfg_index_i == mmf3_pkg::CFG_IMAGE_WIDTH) ||
                    (cfg_index_i == mmf3_pkg::CFG_IMAGE_HEIGHT));

  always_comb begin
    if (width_q == '0) begin
      eff_w = (CB+1)'(1);
    end else if (32'(width_q) > LINE_MAX) begin
      eff_w = (CB+1)'(LINE_MAX);
    end else begin
      eff_w = (CB+1)'(width_q);
    end
  end

  assign eff_h = (height_q == '0) ? mmf3_pkg::HEIGHT_W'(1) : height_q;

  mmf3_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .eff_w_i   (eff_w),
    .eff_h_i   (eff_h),
    .restart_i (restart),
    .room_i    (room),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  mmf3_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry),
    .room_o  (room)
  );

  mmf3_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .q_valid_i (q_valid),
    .entry_i   (pop_entry),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
